@@ hdl/smi_pkg.sv @@
// shared types, widths and saturation helper for the small matrix inverse block
package smi_pkg;

	localparam int EW      = 32;   // element width
	localparam int NLANE   = 9;    // one lane per matrix element
	localparam int COF_W   = 64;   // exact 2x2 minor
	localparam int TERM_W  = 96;   // element times minor
	localparam int DSUM_W  = 98;   // sum of three terms
	localparam int DMAG_W  = 97;   // determinant magnitude
	localparam int QW      = 32;   // quotient bits resolved by the divider
	localparam int DIV_W   = 130;  // divider remainder, covers fraction widths up to 33 bits
	localparam int DIV_LAT = QW + 1;

	typedef logic signed [EW-1:0] elem_t;

	typedef enum logic [1:0] {
		OP_INV     = 2'd0,
		OP_COF     = 2'd1,
		OP_DET     = 2'd2,
		OP_DET_ALT = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_SING = 2'd1,
		ST_SAT  = 2'd2
	} status_t;

	typedef struct packed {
		logic          sat;
		logic [EW-1:0] val;
	} satv_t;

	typedef struct packed {
		op_t           op;
		logic          dzero;
		satv_t         det;
	} ctrl_t;

	// magnitude and sign to a saturated 32-bit two's complement value
	function automatic satv_t sat_q32(input logic neg, input logic [DIV_W-1:0] mag);
		satv_t            r;
		logic [DIV_W-1:0] lim;
		lim   = neg ? DIV_W'(33'h080000000) : DIV_W'(33'h07fffffff);
		r.sat = mag > lim;
		if (r.sat) begin
			r.val = neg ? 32'h80000000 : 32'h7fffffff;
		end else begin
			r.val = neg ? (~mag[EW-1:0] + 32'd1) : mag[EW-1:0];
		end
		return r;
	endfunction

endpackage

@@ hdl/small_matrix_inverse_det.sv @@
// top level: input skid, front end, nine divider lanes and merge stage
// Accepts one matrix of up to 3x3 signed Q16.16 elements per cycle and returns, one
// item per input, the inverse with determinant, the cofactor matrix (reciprocal for
// dimension one) or the determinant alone, all exact before truncation toward zero and
// saturation to 32 bits. On its way to the output an item passes 6 stages of products,
// minors and determinant, 33 stages in each of the nine divider lanes (one overflow
// check plus one quotient bit per stage) and the output register. Throughput is one
// item per cycle while the output is not stalled. A stalled output freezes the whole
// pipeline; a one-item skid buffer on the input still takes one more item in that case.
module small_matrix_inverse_det #(
	parameter int DIM       = 3,
	parameter int FRAC_BITS = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [287:0] s_axis_tdata,   // e00, e01, e02, e10, e11, e12, e20, e21, e22
	input  logic [1:0]   s_axis_tuser,   // opcode
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [319:0] m_axis_tdata,   // r00, r01, r02, r10, r11, r12, r20, r21, r22, det_value
	output logic [1:0]   m_axis_tuser    // status
);
	localparam int NL  = smi_pkg::NLANE;
	localparam int LAT = smi_pkg::DIV_LAT;

	logic         adv;
	logic         in_fire;
	logic         skid_full_q;
	logic [287:0] skid_data_q;
	logic [1:0]   skid_user_q;
	logic         pipe_valid;
	logic [287:0] pipe_data;
	logic [1:0]   pipe_user;
	smi_pkg::elem_t pipe_e [NL];

	logic                       f_valid;
	smi_pkg::ctrl_t             f_ctrl;
	logic [smi_pkg::DMAG_W-1:0] f_dmag;
	logic [smi_pkg::COF_W-1:0]  f_num [NL];
	logic                       f_neg [NL];
	smi_pkg::satv_t             f_byp [NL];

	smi_pkg::satv_t             l_div [NL];
	smi_pkg::satv_t             l_byp [NL];

	logic                       vld_q [LAT];
	smi_pkg::ctrl_t             ctrl_q [LAT];

	smi_pkg::elem_t             o_r [NL];
	smi_pkg::elem_t             o_det;
	smi_pkg::status_t           o_status;

	assign adv           = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = !skid_full_q;
	assign in_fire       = s_axis_tvalid && s_axis_tready;

	assign pipe_valid = skid_full_q || s_axis_tvalid;
	assign pipe_data  = skid_full_q ? skid_data_q : s_axis_tdata;
	assign pipe_user  = skid_full_q ? skid_user_q : s_axis_tuser;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skid_full_q <= 1'b0;
		end else if (adv) begin
			skid_full_q <= 1'b0;
		end else if (in_fire) begin
			skid_full_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire && !adv) begin
			skid_data_q <= s_axis_tdata;
			skid_user_q <= s_axis_tuser;
		end
	end

	for (genvar k = 0; k < NL; k++) begin : g_unpack
		assign pipe_e[k] = pipe_data[k*32 +: 32];
	end

	smi_front #(
		.DIM       (DIM),
		.FRAC_BITS (FRAC_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.in_valid  (pipe_valid),
		.in_op     (smi_pkg::op_t'(pipe_user)),
		.in_e      (pipe_e),
		.out_valid (f_valid),
		.out_ctrl  (f_ctrl),
		.out_dmag  (f_dmag),
		.out_num   (f_num),
		.out_neg   (f_neg),
		.out_byp   (f_byp)
	);

	for (genvar k = 0; k < NL; k++) begin : g_lane
		smi_lane #(
			.FRAC_BITS (FRAC_BITS)
		) u_lane (
			.clk     (clk),
			.en      (adv),
			.num     (f_num[k]),
			.dmag    (f_dmag),
			.neg     (f_neg[k]),
			.byp     (f_byp[k]),
			.div_res (l_div[k]),
			.byp_res (l_byp[k])
		);
	end

	// item control rides alongside the lanes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < LAT; k++) vld_q[k] <= 1'b0;
		end else if (adv) begin
			vld_q[0] <= f_valid;
			for (int k = 1; k < LAT; k++) vld_q[k] <= vld_q[k-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ctrl_q[0] <= f_ctrl;
			for (int k = 1; k < LAT; k++) ctrl_q[k] <= ctrl_q[k-1];
		end
	end

	smi_merge #(
		.DIM (DIM)
	) u_merge (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (adv),
		.in_valid   (vld_q[LAT-1]),
		.ctrl       (ctrl_q[LAT-1]),
		.div_res    (l_div),
		.byp_res    (l_byp),
		.out_valid  (m_axis_tvalid),
		.out_r      (o_r),
		.out_det    (o_det),
		.out_status (o_status)
	);

	for (genvar k = 0; k < NL; k++) begin : g_pack
		assign m_axis_tdata[k*32 +: 32] = o_r[k];
	end
	assign m_axis_tdata[319:288] = o_det;
	assign m_axis_tuser          = o_status;

endmodule

@@ hdl/smi_front.sv @@
// minors, determinant and per-lane divider operands
module smi_front #(
	parameter int DIM       = 3,
	parameter int FRAC_BITS = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic                        in_valid,
	input  smi_pkg::op_t                in_op,
	input  smi_pkg::elem_t              in_e [smi_pkg::NLANE],
	output logic                        out_valid,
	output smi_pkg::ctrl_t              out_ctrl,
	output logic [smi_pkg::DMAG_W-1:0]  out_dmag,
	output logic [smi_pkg::COF_W-1:0]   out_num [smi_pkg::NLANE],
	output logic                        out_neg [smi_pkg::NLANE],
	output smi_pkg::satv_t              out_byp [smi_pkg::NLANE]
);
	localparam int COF_SH = (DIM >= 2) ? (DIM - 2) * FRAC_BITS : 0;
	localparam int DET_SH = (DIM - 1) * FRAC_BITS;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	smi_pkg::op_t op_s1, op_s2, op_s3, op_s4, op_s5, op_s6;

	logic signed [smi_pkg::COF_W-1:0]  p0_c [smi_pkg::NLANE];
	logic signed [smi_pkg::COF_W-1:0]  p1_c [smi_pkg::NLANE];
	logic signed [smi_pkg::COF_W-1:0]  p0_s1 [smi_pkg::NLANE];
	logic signed [smi_pkg::COF_W-1:0]  p1_s1 [smi_pkg::NLANE];
	smi_pkg::elem_t                    e0_s1 [3];
	smi_pkg::elem_t                    e0_s2 [3];
	logic signed [smi_pkg::COF_W-1:0]  cof_s2 [smi_pkg::NLANE];
	logic signed [smi_pkg::COF_W-1:0]  cof_s3 [smi_pkg::NLANE];
	logic signed [smi_pkg::COF_W-1:0]  cof_s4 [smi_pkg::NLANE];
	logic signed [smi_pkg::COF_W-1:0]  cof_s5 [smi_pkg::NLANE];
	logic signed [64:0]                lo_c [3];
	logic signed [63:0]                hi_c [3];
	logic signed [64:0]                lo_s3 [3];
	logic signed [63:0]                hi_s3 [3];
	logic signed [smi_pkg::TERM_W-1:0] term_s4 [3];
	logic signed [smi_pkg::DSUM_W-1:0] dsum_s5;

	logic                              dneg_c;
	logic [smi_pkg::DMAG_W-1:0]        dmag_c;
	logic [smi_pkg::COF_W-1:0]         num_c [smi_pkg::NLANE];
	logic                              neg_c [smi_pkg::NLANE];
	smi_pkg::satv_t                    byp_c [smi_pkg::NLANE];
	smi_pkg::ctrl_t                    ctrl_c;

	logic [smi_pkg::DMAG_W-1:0]        dmag_s6;
	logic [smi_pkg::COF_W-1:0]         num_s6 [smi_pkg::NLANE];
	logic                              neg_s6 [smi_pkg::NLANE];
	smi_pkg::satv_t                    byp_s6 [smi_pkg::NLANE];
	smi_pkg::ctrl_t                    ctrl_s6;

	// products of the 2x2 minors; for dimension two the minor is a single element
	always_comb begin
		int a, b, c, d;
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) begin
				a = (i == 0) ? 1 : 0;
				b = (i == 2) ? 1 : 2;
				c = (j == 0) ? 1 : 0;
				d = (j == 2) ? 1 : 2;
				p0_c[i*3+j] = '0;
				p1_c[i*3+j] = '0;
				if (DIM == 2 && i < 2 && j < 2) begin
					p0_c[i*3+j] = smi_pkg::COF_W'(in_e[(1-i)*3+(1-j)]);
				end else if (DIM == 3) begin
					p0_c[i*3+j] = smi_pkg::COF_W'(in_e[a*3+c]) * smi_pkg::COF_W'(in_e[b*3+d]);
					p1_c[i*3+j] = smi_pkg::COF_W'(in_e[a*3+d]) * smi_pkg::COF_W'(in_e[b*3+c]);
				end
			end
		end
	end

	// row 0 expansion, minor split into two 32-bit halves
	always_comb begin
		for (int j = 0; j < 3; j++) begin
			lo_c[j] = '0;
			hi_c[j] = '0;
			if (DIM == 1) begin
				if (j == 0) lo_c[j] = 65'(e0_s2[j]);
			end else if (j < DIM) begin
				lo_c[j] = 65'(e0_s2[j]) * $signed({1'b0, cof_s2[j][31:0]});
				hi_c[j] = 64'(e0_s2[j]) * 64'($signed(cof_s2[j][63:32]));
			end
		end
	end

	// sign, magnitude and lane operands
	always_comb begin
		logic                      cn;
		logic [smi_pkg::COF_W-1:0] cm;
		dneg_c = dsum_s5[smi_pkg::DSUM_W-1];
		dmag_c = dneg_c ? smi_pkg::DMAG_W'(-dsum_s5) : smi_pkg::DMAG_W'(dsum_s5);
		ctrl_c.op    = op_s5;
		ctrl_c.dzero = (dsum_s5 == '0);
		ctrl_c.det   = smi_pkg::sat_q32(dneg_c, smi_pkg::DIV_W'(dmag_c >> DET_SH));
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) begin
				// adjugate entry is the transposed minor
				cn = cof_s5[j*3+i][smi_pkg::COF_W-1];
				if (DIM == 1) begin
					num_c[i*3+j] = (i == 0 && j == 0) ? smi_pkg::COF_W'(1) : '0;
					neg_c[i*3+j] = dneg_c;
				end else begin
					num_c[i*3+j] = cn ? -cof_s5[j*3+i] : cof_s5[j*3+i];
					neg_c[i*3+j] = cn ^ dneg_c;
				end
				cn = cof_s5[i*3+j][smi_pkg::COF_W-1];
				cm = cn ? -cof_s5[i*3+j] : cof_s5[i*3+j];
				byp_c[i*3+j] = smi_pkg::sat_q32(cn, smi_pkg::DIV_W'(cm >> COF_SH));
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			op_s1 <= in_op;
			op_s2 <= op_s1;
			op_s3 <= op_s2;
			op_s4 <= op_s3;
			op_s5 <= op_s4;
			for (int j = 0; j < 3; j++) begin
				e0_s1[j]   <= in_e[j];
				e0_s2[j]   <= e0_s1[j];
				lo_s3[j]   <= lo_c[j];
				hi_s3[j]   <= hi_c[j];
				term_s4[j] <= (smi_pkg::TERM_W'(hi_s3[j]) <<< 32) + smi_pkg::TERM_W'(lo_s3[j]);
			end
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					p0_s1[i*3+j]  <= p0_c[i*3+j];
					p1_s1[i*3+j]  <= p1_c[i*3+j];
					cof_s2[i*3+j] <= ((i + j) % 2 == 1) ? p1_s1[i*3+j] - p0_s1[i*3+j]
					                                      : p0_s1[i*3+j] - p1_s1[i*3+j];
				end
			end
			for (int k = 0; k < smi_pkg::NLANE; k++) begin
				cof_s3[k] <= cof_s2[k];
				cof_s4[k] <= cof_s3[k];
				cof_s5[k] <= cof_s4[k];
				num_s6[k] <= num_c[k];
				neg_s6[k] <= neg_c[k];
				byp_s6[k] <= byp_c[k];
			end
			dsum_s5 <= smi_pkg::DSUM_W'(term_s4[0]) + smi_pkg::DSUM_W'(term_s4[1])
			         + smi_pkg::DSUM_W'(term_s4[2]);
			dmag_s6 <= dmag_c;
			ctrl_s6 <= ctrl_c;
			op_s6   <= op_s5;
		end
	end

	assign out_valid = v_s6;
	assign out_dmag  = dmag_s6;
	always_comb begin
		out_ctrl    = ctrl_s6;
		out_ctrl.op = op_s6;
		for (int k = 0; k < smi_pkg::NLANE; k++) begin
			out_num[k] = num_s6[k];
			out_neg[k] = neg_s6[k];
			out_byp[k] = byp_s6[k];
		end
	end

endmodule

@@ hdl/smi_lane.sv @@
// one lane: pipelined restoring divider, one quotient bit per stage
module smi_lane #(
	parameter int FRAC_BITS = 16
) (
	input  logic                       clk,
	input  logic                       en,
	input  logic [smi_pkg::COF_W-1:0]  num,
	input  logic [smi_pkg::DMAG_W-1:0] dmag,
	input  logic                       neg,
	input  smi_pkg::satv_t             byp,
	output smi_pkg::satv_t             div_res,
	output smi_pkg::satv_t             byp_res
);
	localparam int QW = smi_pkg::QW;

	logic [smi_pkg::DIV_W-1:0]  rem_s [QW+1];
	logic [QW-1:0]              quo_s [QW+1];
	logic [smi_pkg::DMAG_W-1:0] den_s [QW+1];
	logic                       ovf_s [QW+1];
	logic                       neg_s [QW+1];
	smi_pkg::satv_t             byp_s [QW+1];

	logic [smi_pkg::DIV_W-1:0]  num_ext;
	logic [smi_pkg::DIV_W-1:0]  den_top;

	assign num_ext = smi_pkg::DIV_W'(num) << (2 * FRAC_BITS);
	assign den_top = smi_pkg::DIV_W'(dmag) << QW;

	// quotient of 2^32 or more always saturates
	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= num_ext;
			quo_s[0] <= '0;
			den_s[0] <= dmag;
			ovf_s[0] <= num_ext >= den_top;
			neg_s[0] <= neg;
			byp_s[0] <= byp;
		end
	end

	for (genvar k = 1; k <= QW; k++) begin : g_step
		logic [smi_pkg::DIV_W-1:0] dsh;
		logic                      take;
		assign dsh  = smi_pkg::DIV_W'(den_s[k-1]) << (QW - k);
		assign take = rem_s[k-1] >= dsh;
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k] <= take ? rem_s[k-1] - dsh : rem_s[k-1];
				quo_s[k] <= quo_s[k-1] | (take ? (QW'(1) << (QW - k)) : '0);
				den_s[k] <= den_s[k-1];
				ovf_s[k] <= ovf_s[k-1];
				neg_s[k] <= neg_s[k-1];
				byp_s[k] <= byp_s[k-1];
			end
		end
	end

	always_comb begin
		div_res = smi_pkg::sat_q32(neg_s[QW], smi_pkg::DIV_W'(quo_s[QW]));
		if (ovf_s[QW]) begin
			div_res.sat = 1'b1;
			div_res.val = neg_s[QW] ? 32'h80000000 : 32'h7fffffff;
		end
	end
	assign byp_res = byp_s[QW];

endmodule

@@ hdl/smi_merge.sv @@
// merges lane results by opcode, sets status and holds the output item
module smi_merge #(
	parameter int DIM = 3
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   en,
	input  logic                   in_valid,
	input  smi_pkg::ctrl_t         ctrl,
	input  smi_pkg::satv_t         div_res [smi_pkg::NLANE],
	input  smi_pkg::satv_t         byp_res [smi_pkg::NLANE],
	output logic                   out_valid,
	output smi_pkg::elem_t         out_r [smi_pkg::NLANE],
	output smi_pkg::elem_t         out_det,
	output smi_pkg::status_t       out_status
);
	logic              valid_q;
	smi_pkg::elem_t    r_q [smi_pkg::NLANE];
	smi_pkg::elem_t    det_q;
	smi_pkg::status_t  status_q;

	smi_pkg::elem_t    r_c [smi_pkg::NLANE];
	smi_pkg::elem_t    det_c;
	smi_pkg::status_t  status_c;

	always_comb begin
		logic cof_mode, inv_mode, sing, any_sat;
		cof_mode = (ctrl.op == smi_pkg::OP_COF);
		// dimension one turns the cofactor request into the reciprocal
		inv_mode = (ctrl.op == smi_pkg::OP_INV) || (cof_mode && DIM == 1);
		sing     = (inv_mode || !cof_mode) && ctrl.dzero;
		any_sat  = ctrl.det.sat;
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) begin
				r_c[i*3+j] = '0;
				if (i < DIM && j < DIM && !sing) begin
					if (inv_mode) begin
						r_c[i*3+j] = div_res[i*3+j].val;
						any_sat    = any_sat | div_res[i*3+j].sat;
					end else if (cof_mode) begin
						r_c[i*3+j] = byp_res[i*3+j].val;
						any_sat    = any_sat | byp_res[i*3+j].sat;
					end
				end
			end
		end
		det_c = sing ? '0 : ctrl.det.val;
		if (sing) begin
			status_c = smi_pkg::ST_SING;
		end else if (any_sat) begin
			status_c = smi_pkg::ST_SAT;
		end else begin
			status_c = smi_pkg::ST_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < smi_pkg::NLANE; k++) r_q[k] <= r_c[k];
			det_q    <= det_c;
			status_q <= status_c;
		end
	end

	assign out_valid  = valid_q;
	assign out_det    = det_q;
	assign out_status = status_q;
	always_comb begin
		for (int k = 0; k < smi_pkg::NLANE; k++) out_r[k] = r_q[k];
	end

endmodule

@@ hdl/smi_checker.sv @@
// port-level checks for the small matrix inverse block, bound to the top level
module smi_checker (
	input logic         clk,
	input logic         arst_n,
	input logic         s_axis_tvalid,
	input logic         s_axis_tready,
	input logic [287:0] s_axis_tdata,
	input logic [1:0]   s_axis_tuser,
	input logic         m_axis_tvalid,
	input logic         m_axis_tready,
	input logic [319:0] m_axis_tdata,
	input logic [1:0]   m_axis_tuser
);
	// no status code beyond saturated
	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tuser != 2'd3))
		else $error("undefined status code");

	// a singular item carries all zero elements and determinant
	a_sing_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser == smi_pkg::ST_SING) |-> (m_axis_tdata == '0))
		else $error("singular item with nonzero data");

	// input side only backs off after an output stall
	a_ready_drop: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(s_axis_tready) |-> $past(m_axis_tvalid && !m_axis_tready))
		else $error("input ready dropped without output stall");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=>
			(m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
		else $error("stalled output item changed");

endmodule

bind small_matrix_inverse_det smi_checker u_smi_checker (.*);
